FILE: hdl/turbine_power_coefficient_assert.svh
// Assertion macros for the turbine power coefficient block.
// Included by the top level; no other dependencies.
`ifndef TURBINE_POWER_COEFFICIENT_ASSERT_SVH
`define TURBINE_POWER_COEFFICIENT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge.
`define TPC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tpc: check failed");
// Next-cycle implication, sampled on the rising clock edge.
`define TPC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tpc: check failed");
`else
`define TPC_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define TPC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: hdl/tpc_pkg.sv
// Shared constants, types and fixed-point helpers of the power coefficient block.
// No dependencies; used by the divider, the exponential pipeline and the top level.
`timescale 1ns / 1ps

package tpc_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned WORD_WIDTH = 32;
  localparam int unsigned DIV_BITS   = 48;
  localparam int unsigned EXP_TERMS  = 12;
  localparam int unsigned NUM_COEFS  = 8;

  localparam logic signed [63:0] ONE_Q     = 64'sd65536;
  localparam logic signed [31:0] CP_MAX    = 32'sd131072;
  localparam logic signed [31:0] WORD_MAX  = 32'sh7fff_ffff;
  localparam logic signed [31:0] WORD_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
  localparam logic [29:0]        LN2_Q30   = 30'd744261118;

  // Coefficient register indexes
  typedef enum logic [2:0] {
    REG_C1, REG_C2, REG_C3, REG_C4, REG_C5, REG_C6, REG_C7, REG_C8
  } tpc_reg_e;

  localparam logic [31:0] COEF_RESET [NUM_COEFS] = '{
    32'd14418, 32'd7602176, 32'd26214, 32'd327680,
    32'd819200, 32'd0, 32'd5243, 32'd2294
  };

  // Sideband that travels alongside the divider lanes
  typedef struct packed {
    logic        valid;
    logic        fault;
    logic        neg1;
    logic        neg2;
    logic [21:0] lam;
    logic [23:0] pitch;
  } tpc_div_side_t;

  // Sideband that travels alongside the exponential pipeline
  typedef struct packed {
    logic        valid;
    logic        fault;
    logic [31:0] inner;
    logic [31:0] lin;
  } tpc_exp_side_t;

  // Arithmetic shift right with the magnitude truncated (round toward zero)
  function automatic logic signed [63:0] trunc_sh(input logic signed [63:0] v,
                                                  input int unsigned sh);
    logic signed [63:0] s;
    logic [63:0]        mask;
    s    = v >>> sh;
    mask = (64'd1 << sh) - 64'd1;
    if (v < 0 && (v & mask) != 64'd0) begin
      s = s + 64'sd1;
    end
    return s;
  endfunction

  // Saturate to the signed word range
  function automatic logic signed [31:0] sat_w(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(WORD_MAX)) begin
      r = WORD_MAX;
    end else if (v < 64'(WORD_MIN)) begin
      r = WORD_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/tpc_div_pipe.sv
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on tpc_pkg for the stage count and the sideband type.
`timescale 1ns / 1ps

module tpc_div_pipe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [tpc_pkg::DIV_BITS-1:0]  num1_i,
  input  logic [31:0]                   den1_i,
  input  logic [tpc_pkg::DIV_BITS-1:0]  num2_i,
  input  logic [31:0]                   den2_i,
  input  tpc_pkg::tpc_div_side_t        side_i,
  output logic [tpc_pkg::DIV_BITS-1:0]  quo1_o,
  output logic [tpc_pkg::DIV_BITS-1:0]  quo2_o,
  output tpc_pkg::tpc_div_side_t        side_o
);

  typedef struct packed {
    logic [31:0]                  rem;
    logic [tpc_pkg::DIV_BITS-1:0] word;
    logic [31:0]                  den;
  } lane_t;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  function automatic lane_t div_step(input lane_t l);
    logic [32:0] rs;
    logic        ge;
    lane_t       o;
    rs     = {l.rem, l.word[tpc_pkg::DIV_BITS-1]};
    ge     = rs >= {1'b0, l.den};
    o.den  = l.den;
    o.rem  = ge ? 32'(rs - {1'b0, l.den}) : rs[31:0];
    o.word = {l.word[tpc_pkg::DIV_BITS-2:0], ge};
    return o;
  endfunction

  lane_t                  l1_q   [tpc_pkg::DIV_BITS];
  lane_t                  l2_q   [tpc_pkg::DIV_BITS];
  tpc_pkg::tpc_div_side_t side_q [tpc_pkg::DIV_BITS];

  for (genvar i = 0; i < tpc_pkg::DIV_BITS; i++) begin : g_stage
    lane_t                  a1;
    lane_t                  a2;
    tpc_pkg::tpc_div_side_t s_in;

    if (i == 0) begin : g_first
      assign a1   = '{rem: 32'd0, word: num1_i, den: den1_i};
      assign a2   = '{rem: 32'd0, word: num2_i, den: den2_i};
      assign s_in = side_i;
    end else begin : g_next
      assign a1   = l1_q[i-1];
      assign a2   = l2_q[i-1];
      assign s_in = side_q[i-1];
    end

    // Advance both lanes by one quotient bit
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        l1_q[i] <= div_step(a1);
        l2_q[i] <= div_step(a2);
      end
    end

    // Carry valid and sideband with the lanes
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[i] <= '0;
      end else if (en_i) begin
        side_q[i] <= s_in;
      end
    end
  end

  assign quo1_o = l1_q[tpc_pkg::DIV_BITS-1].word;
  assign quo2_o = l2_q[tpc_pkg::DIV_BITS-1].word;
  assign side_o = side_q[tpc_pkg::DIV_BITS-1];

endmodule

FILE: hdl/tpc_exp_pipe.sv
// Pipelined fixed-point exponential: base-2 split and a Taylor series for 2^f.
// Depends on tpc_pkg for constants, helpers and the sideband type.
`timescale 1ns / 1ps

module tpc_exp_pipe (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic signed [31:0]     x_i,
  input  tpc_pkg::tpc_exp_side_t side_i,
  output logic signed [31:0]     ex_o,
  output tpc_pkg::tpc_exp_side_t side_o
);

  localparam logic signed [31:0] XLim  = 32'sd4194304;
  localparam logic signed [8:0]  SBias = 9'sd14;

  typedef struct packed {
    tpc_pkg::tpc_exp_side_t side;
    logic [7:0]             n;
    logic [29:0]            g;
    logic [31:0]            sum;
  } carry_t;

  tpc_pkg::tpc_exp_side_t side0_q, side1_q, side2_q, out_side_q;
  logic signed [23:0] xc_q;
  logic signed [54:0] yraw_q;
  logic [7:0]         n2_q;
  logic [15:0]        f2_q;
  carry_t             carry0_q;
  logic signed [63:0] y_full;
  logic [45:0]        gp;
  logic signed [31:0] ex_q;

  // Clamp the argument, scale by log2(e), split into integer and fraction
  assign y_full = tpc_pkg::trunc_sh(64'(yraw_q), 30);
  assign gp     = 46'(f2_q) * 46'(tpc_pkg::LN2_Q30);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (x_i > XLim) begin
        xc_q <= 24'(XLim);
      end else if (x_i < -XLim) begin
        xc_q <= 24'(-XLim);
      end else begin
        xc_q <= x_i[23:0];
      end
      yraw_q <= 55'(xc_q) * 55'(tpc_pkg::LOG2E_Q30);
      n2_q   <= y_full[23:16];
      f2_q   <= y_full[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side0_q  <= '0;
      side1_q  <= '0;
      side2_q  <= '0;
      carry0_q <= '0;
    end else if (en_i) begin
      side0_q  <= side_i;
      side1_q  <= side0_q;
      side2_q  <= side1_q;
      carry0_q <= '{side: side2_q, n: n2_q, g: gp[45:16], sum: 32'h4000_0000};
    end
  end

  // Series terms: multiply by g, then divide by k via reciprocal and correction
  carry_t      ca_q   [tpc_pkg::EXP_TERMS];
  carry_t      cb_q   [tpc_pkg::EXP_TERMS];
  carry_t      cc_q   [tpc_pkg::EXP_TERMS];
  logic [29:0] xa_q   [tpc_pkg::EXP_TERMS];
  logic [29:0] xb_q   [tpc_pkg::EXP_TERMS];
  logic [63:0] qm_q   [tpc_pkg::EXP_TERMS];
  logic [30:0] term_q [tpc_pkg::EXP_TERMS];

  for (genvar kk = 0; kk < tpc_pkg::EXP_TERMS; kk++) begin : g_term
    localparam logic [33:0] KVal  = 34'(kk + 1);
    localparam logic [33:0] Recip = 34'((64'd1 << 33) / (kk + 1));

    logic [30:0] term_in;
    carry_t      carry_in;
    logic [60:0] prod;
    logic [29:0] q0;
    logic [33:0] rem;
    logic [29:0] quo;

    if (kk == 0) begin : g_first
      assign term_in  = 31'h4000_0000;
      assign carry_in = carry0_q;
    end else begin : g_next
      assign term_in  = term_q[kk-1];
      assign carry_in = cc_q[kk-1];
    end

    assign prod = 61'(term_in) * 61'(carry_in.g);
    assign q0   = qm_q[kk][62:33];
    assign rem  = 34'(xb_q[kk]) - 34'(q0) * KVal;
    assign quo  = (rem >= KVal) ? q0 + 30'd1 : q0;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        xa_q[kk]   <= prod[59:30];
        qm_q[kk]   <= 64'(xa_q[kk]) * 64'(Recip);
        xb_q[kk]   <= xa_q[kk];
        term_q[kk] <= 31'(quo);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ca_q[kk] <= '0;
        cb_q[kk] <= '0;
        cc_q[kk] <= '0;
      end else if (en_i) begin
        ca_q[kk] <= carry_in;
        cb_q[kk] <= ca_q[kk];
        cc_q[kk] <= '{side: cb_q[kk].side, n: cb_q[kk].n, g: cb_q[kk].g,
                      sum: cb_q[kk].sum + 32'(quo)};
      end
    end
  end

  // Scale the series by 2^n and saturate
  carry_t             last;
  logic signed [8:0]  sh;
  logic [8:0]         nsh;
  logic [63:0]        wide;
  logic signed [31:0] ex_d;

  assign last = cc_q[tpc_pkg::EXP_TERMS-1];

  always_comb begin
    sh   = 9'($signed(last.n)) - SBias;
    nsh  = 9'(-sh);
    wide = 64'(last.sum) << sh[4:0];
    if (!sh[8]) begin
      if (sh >= 9'sd32) begin
        ex_d = tpc_pkg::WORD_MAX;
      end else if (wide > 64'(tpc_pkg::WORD_MAX)) begin
        ex_d = tpc_pkg::WORD_MAX;
      end else begin
        ex_d = wide[31:0];
      end
    end else if (nsh >= 9'd32) begin
      ex_d = 32'sd0;
    end else begin
      ex_d = last.sum >> nsh[4:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ex_q <= ex_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_side_q <= '0;
    end else if (en_i) begin
      out_side_q <= last.side;
    end
  end

  assign ex_o   = ex_q;
  assign side_o = out_side_q;

endmodule

FILE: hdl/turbine_power_coefficient.sv
// Top level of the turbine power coefficient block: Cp(lambda, pitch) pipeline.
// Depends on tpc_pkg, tpc_div_pipe, tpc_exp_pipe and the assertion header.
//
// Usage:
//   Input channel: in_valid_i with tip_speed_ratio_i and pitch_angle_i, held
//   off by in_stall_o. A transfer happens when valid is high and stall low.
//   Output channel: out_valid_o with power_coeff_o, clamped_o and div_fault_o,
//   held off by out_stall_i.
//   Coefficients C1..C8 are written through cfg_we_i, cfg_index_i and
//   cfg_data_i (index 0 is C1); write them only while the pipeline is empty.
//   Throughput is one operating point per cycle while the output is not
//   stalled; depth is set by the two 48-stage pipelined divider lanes and
//   the 41-stage exponential pipeline.
//   Reset empties the pipeline and loads the default curve coefficients.
//   While the receiver stalls a valid result, the whole pipeline freezes and
//   in_stall_o rises; nothing is lost or repeated.
//   A zero divisor gives power_coeff 0 with div_fault set; a result outside
//   0..2.0 is limited and flagged on clamped.
`timescale 1ns / 1ps
`include "turbine_power_coefficient_assert.svh"

module turbine_power_coefficient (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [21:0]        tip_speed_ratio_i,
  input  logic signed [23:0] pitch_angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [17:0]        power_coeff_o,
  output logic               clamped_o,
  output logic               div_fault_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned FB = tpc_pkg::FRAC_BITS;

  logic adv;

  // Coefficient registers
  logic signed [31:0] coef_q [tpc_pkg::NUM_COEFS];
  logic signed [31:0] c1, c2, c3, c4, c5, c6, c7, c8;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tpc_pkg::NUM_COEFS; i++) begin
        coef_q[i] <= tpc_pkg::COEF_RESET[i];
      end
    end else if (cfg_we_i) begin
      coef_q[cfg_index_i] <= cfg_data_i;
    end
  end

  assign c1 = coef_q[tpc_pkg::REG_C1];
  assign c2 = coef_q[tpc_pkg::REG_C2];
  assign c3 = coef_q[tpc_pkg::REG_C3];
  assign c4 = coef_q[tpc_pkg::REG_C4];
  assign c5 = coef_q[tpc_pkg::REG_C5];
  assign c6 = coef_q[tpc_pkg::REG_C6];
  assign c7 = coef_q[tpc_pkg::REG_C7];
  assign c8 = coef_q[tpc_pkg::REG_C8];

  // Whole pipeline advances unless a finished result is held by the receiver
  logic out_valid_q;
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Valid bits
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v7_q, v8_q, v9_q, v11_q, v12_q, v13_q;

  // Payload registers
  logic [21:0]        lam1_q, lam2_q, lam3_q, lam4_q, lam5_q, lam7_q, lam8_q;
  logic signed [23:0] pit1_q, pit2_q, pit3_q, pit4_q, pit5_q, pit7_q, pit8_q;
  logic signed [63:0] c7p2_q, psq2_q, pcb4_q;
  logic signed [31:0] d1_3_q, psq3_q, d1_4_q, d1_5_q, d2_5_q;
  logic               fault7_q, fault8_q, fault9_q, fault11_q, fault12_q, fault13_q;
  logic signed [31:0] inv1_7_q, t2_7_q, invl8_q;
  logic signed [63:0] araw9_q, eraw9_q, braw9_q, lraw9_q;
  logic signed [31:0] earg10_q;
  logic signed [31:0] lin11_q, lin12_q, lin13_q, ex11_q, ex12_q, m1_12_q;
  logic signed [63:0] m1raw11_q, traw13_q;
  logic [17:0]        power_coeff_q;
  logic               clamped_q, div_fault_q;

  // Divider stage inputs
  tpc_pkg::tpc_div_side_t         dside6_q, dside_out;
  logic [tpc_pkg::DIV_BITS-1:0]   num1_6_q, num2_6_q, quo1, quo2;
  logic [31:0]                    den1_6_q, den2_6_q;

  // Exponential stage inputs
  tpc_pkg::tpc_exp_side_t eside10_q, eside_out;
  logic signed [31:0]     ex_out;

  // Combinational values between stages
  logic signed [31:0] d1_d, psq_d, pcube_d, d2_d;
  logic signed [31:0] inv1_d, t2_d, invl_d;
  logic signed [31:0] a_d, b_d, inner_d, em_d, earg_d, lin_d;
  logic signed [31:0] t_d, cp_d;
  logic [31:0]        c8_mag;

  assign d1_d    = tpc_pkg::sat_w(64'($signed({1'b0, lam2_q}))
                                  + tpc_pkg::trunc_sh(c7p2_q, FB));
  assign psq_d   = tpc_pkg::sat_w(tpc_pkg::trunc_sh(psq2_q, FB));
  assign pcube_d = tpc_pkg::sat_w(tpc_pkg::trunc_sh(pcb4_q, FB));
  assign d2_d    = tpc_pkg::sat_w(64'(pcube_d) + tpc_pkg::ONE_Q);
  assign c8_mag  = c8[31] ? 32'(-c8) : c8;

  assign inv1_d = tpc_pkg::sat_w(dside_out.neg1 ? -$signed(64'(quo1))
                                                : $signed(64'(quo1)));
  assign t2_d   = tpc_pkg::sat_w(dside_out.neg2 ? -$signed(64'(quo2))
                                                : $signed(64'(quo2)));
  assign invl_d = tpc_pkg::sat_w(64'(inv1_7_q) - 64'(t2_7_q));

  assign a_d     = tpc_pkg::sat_w(tpc_pkg::trunc_sh(araw9_q, FB));
  assign b_d     = tpc_pkg::sat_w(tpc_pkg::trunc_sh(braw9_q, FB));
  assign inner_d = tpc_pkg::sat_w(64'(a_d) - 64'(b_d) - 64'(c4));
  assign em_d    = tpc_pkg::sat_w(tpc_pkg::trunc_sh(eraw9_q, FB));
  assign earg_d  = tpc_pkg::sat_w(-64'(em_d));
  assign lin_d   = tpc_pkg::sat_w(tpc_pkg::trunc_sh(lraw9_q, FB));

  assign t_d  = tpc_pkg::sat_w(tpc_pkg::trunc_sh(traw13_q, FB));
  assign cp_d = tpc_pkg::sat_w(64'(t_d) + 64'(lin13_q));

  // Advance the valid bits and the divider and exponential sidebands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      dside6_q    <= '0;
      v7_q        <= 1'b0;
      v8_q        <= 1'b0;
      v9_q        <= 1'b0;
      eside10_q   <= '0;
      v11_q       <= 1'b0;
      v12_q       <= 1'b0;
      v13_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      dside6_q    <= '{valid: v5_q,
                       fault: (d1_5_q == 32'sd0) || (d2_5_q == 32'sd0),
                       neg1:  d1_5_q[31],
                       neg2:  c8[31] ^ d2_5_q[31],
                       lam:   lam5_q,
                       pitch: pit5_q};
      v7_q        <= dside_out.valid;
      v8_q        <= v7_q;
      v9_q        <= v8_q;
      eside10_q   <= '{valid: v9_q, fault: fault9_q, inner: inner_d, lin: lin_d};
      v11_q       <= eside_out.valid;
      v12_q       <= v11_q;
      v13_q       <= v12_q;
      out_valid_q <= v13_q;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // capture the operating point
      lam1_q <= tip_speed_ratio_i;
      pit1_q <= pitch_angle_i;
      // first divisor product and pitch squared
      lam2_q <= lam1_q;
      pit2_q <= pit1_q;
      c7p2_q <= 64'(c7) * 64'(pit1_q);
      psq2_q <= 64'(pit1_q) * 64'(pit1_q);
      // first divisor
      lam3_q <= lam2_q;
      pit3_q <= pit2_q;
      d1_3_q <= d1_d;
      psq3_q <= psq_d;
      // pitch cubed
      lam4_q <= lam3_q;
      pit4_q <= pit3_q;
      d1_4_q <= d1_3_q;
      pcb4_q <= 64'(psq3_q) * 64'(pit3_q);
      // second divisor
      lam5_q <= lam4_q;
      pit5_q <= pit4_q;
      d1_5_q <= d1_4_q;
      d2_5_q <= d2_d;
      // divider operands as magnitudes
      num1_6_q <= tpc_pkg::DIV_BITS'(64'd1 << (2 * FB));
      den1_6_q <= d1_5_q[31] ? 32'(-d1_5_q) : d1_5_q;
      num2_6_q <= tpc_pkg::DIV_BITS'({c8_mag, 16'd0});
      den2_6_q <= d2_5_q[31] ? 32'(-d2_5_q) : d2_5_q;
      // signed quotients
      fault7_q <= dside_out.fault;
      lam7_q   <= dside_out.lam;
      pit7_q   <= $signed(dside_out.pitch);
      inv1_7_q <= inv1_d;
      t2_7_q   <= t2_d;
      // inverse lambda term
      fault8_q <= fault7_q || (invl_d == 32'sd0);
      lam8_q   <= lam7_q;
      pit8_q   <= pit7_q;
      invl8_q  <= invl_d;
      // coefficient products
      fault9_q <= fault8_q;
      araw9_q  <= 64'(c2) * 64'(invl8_q);
      eraw9_q  <= 64'(c5) * 64'(invl8_q);
      braw9_q  <= 64'(c3) * 64'(pit8_q);
      lraw9_q  <= 64'(c6) * 64'($signed({1'b0, lam8_q}));
      // exponent argument
      earg10_q <= earg_d;
      // gain product
      fault11_q <= eside_out.fault;
      lin11_q   <= $signed(eside_out.lin);
      ex11_q    <= ex_out;
      m1raw11_q <= 64'(c1) * 64'($signed(eside_out.inner));
      // scaled gain
      fault12_q <= fault11_q;
      lin12_q   <= lin11_q;
      ex12_q    <= ex11_q;
      m1_12_q   <= tpc_pkg::sat_w(tpc_pkg::trunc_sh(m1raw11_q, FB));
      // times the exponential
      fault13_q <= fault12_q;
      lin13_q   <= lin12_q;
      traw13_q  <= 64'(m1_12_q) * 64'(ex12_q);
      // limit and flag the result
      if (fault13_q) begin
        power_coeff_q <= 18'd0;
        clamped_q     <= 1'b0;
        div_fault_q   <= 1'b1;
      end else if (cp_d < 32'sd0) begin
        power_coeff_q <= 18'd0;
        clamped_q     <= 1'b1;
        div_fault_q   <= 1'b0;
      end else if (cp_d > tpc_pkg::CP_MAX) begin
        power_coeff_q <= tpc_pkg::CP_MAX[17:0];
        clamped_q     <= 1'b1;
        div_fault_q   <= 1'b0;
      end else begin
        power_coeff_q <= cp_d[17:0];
        clamped_q     <= 1'b0;
        div_fault_q   <= 1'b0;
      end
    end
  end

  tpc_div_pipe u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .num1_i (num1_6_q),
    .den1_i (den1_6_q),
    .num2_i (num2_6_q),
    .den2_i (den2_6_q),
    .side_i (dside6_q),
    .quo1_o (quo1),
    .quo2_o (quo2),
    .side_o (dside_out)
  );

  tpc_exp_pipe u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .x_i    (earg10_q),
    .side_i (eside10_q),
    .ex_o   (ex_out),
    .side_o (eside_out)
  );

  assign out_valid_o   = out_valid_q;
  assign power_coeff_o = power_coeff_q;
  assign clamped_o     = clamped_q;
  assign div_fault_o   = div_fault_q;

  // A faulted point carries no coefficient and no limit flag
  `TPC_ASSERT_NOW(a_fault_zero, clk_i, rst_ni, out_valid_o && div_fault_o,
                  power_coeff_o == 18'd0 && !clamped_o)
  // A limited result sits on one of the two bounds
  `TPC_ASSERT_NOW(a_clamp_bound, clk_i, rst_ni, out_valid_o && clamped_o,
                  power_coeff_o == 18'd0 || power_coeff_o == tpc_pkg::CP_MAX[17:0])
  // A held output freezes the pipeline tail
  `TPC_ASSERT_NXT(a_hold_tail, clk_i, rst_ni, !adv,
                  $stable(v13_q) && $stable(traw13_q))

endmodule
